>>> hw/rtl/rgbcct_pkg.sv
// ============================================================================
// rgbcct_pkg: shared constants for the RGB to color temperature block
// Fixed widths of the sample and result fields, the RGB to XYZ matrix in
// signed Q2.14, and the constants of the chromaticity and cubic stages.
// ============================================================================
package rgbcct_pkg;

    localparam int CH_W      = 16;  // raw channel count
    localparam int COEF_W    = 16;  // signed Q2.14 coefficient
    localparam int T_W       = 32;  // one product or one tristimulus value
    localparam int TMAG_W    = 31;  // magnitude of a tristimulus value
    localparam int S_W       = 34;  // X+Y+Z, signed
    localparam int SMAG_W    = 32;  // magnitude of X+Y+Z
    localparam int CCT_W     = 24;
    localparam int LUX_W     = 16;
    localparam int LUX_SHIFT = 14;
    localparam int N_INT_W   = 5;   // |n| stays below 32

    localparam int FRAC_BITS_DEF = 16;

    localparam logic signed [COEF_W-1:0] MAT [3][3] = '{
        '{-16'sd2340,  16'sd25383, -16'sd15670},
        '{-16'sd5319,  16'sd25860, -16'sd11992},
        '{-16'sd11174, 16'sd12628,  16'sd9229}
    };

    // Cubic coefficients, highest power first.
    localparam int POLY_C3 = 437;
    localparam int POLY_C2 = 3601;
    localparam int POLY_C1 = 6861;
    localparam int POLY_C0 = 5517;

    localparam int X0_NUM      = 3320;
    localparam int Y0_NUM      = 1858;
    localparam int SCALE_DEN   = 10000;
    localparam int ZERO_CHROMA = 5000;

    localparam int CCT_MAX = 8388607;
    localparam int CCT_MIN = -8388608;

endpackage

>>> hw/rtl/rgbcct_div_cell.sv
// ============================================================================
// rgbcct_div_cell: one restoring division step
// Shifts one dividend bit into each lane's partial remainder, subtracts the
// shared divisor when it fits, and hands the quotient bit on in the
// accumulator together with the sideband data.
// ============================================================================
module rgbcct_div_cell #(
    parameter int DW = 32,
    parameter int AW = 32,
    parameter int LN = 1,
    parameter int SW = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       vld_in,
    input  logic [DW-1:0]              div_in,
    input  logic [LN-1:0][DW-1:0]      rem_in,
    input  logic [LN-1:0][AW-1:0]      acc_in,
    input  logic [SW-1:0]              side_in,
    output logic                       vld_out,
    output logic [DW-1:0]              div_out,
    output logic [LN-1:0][DW-1:0]      rem_out,
    output logic [LN-1:0][AW-1:0]      acc_out,
    output logic [SW-1:0]              side_out
);

    logic                  vld_reg;
    logic [DW-1:0]         div_reg;
    logic [LN-1:0][DW-1:0] rem_reg;
    logic [LN-1:0][DW-1:0] rem_next;
    logic [LN-1:0][AW-1:0] acc_reg;
    logic [LN-1:0][AW-1:0] acc_next;
    logic [SW-1:0]         side_reg;
    logic [LN-1:0][DW:0]   trial;
    logic [LN-1:0][DW:0]   diff;

    always_comb
    begin
        for (int l = 0; l < LN; l++)
        begin
            trial[l] = {rem_in[l], acc_in[l][AW-1]};
            diff[l]  = trial[l] - {1'b0, div_in};
            // No borrow out of the top bit means the divisor fit.
            if (!diff[l][DW])
            begin
                rem_next[l] = diff[l][DW-1:0];
            end
            else
            begin
                rem_next[l] = trial[l][DW-1:0];
            end
            acc_next[l] = {acc_in[l][AW-2:0], ~diff[l][DW]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg  <= div_in;
        rem_reg  <= rem_next;
        acc_reg  <= acc_next;
        side_reg <= side_in;
    end

    assign vld_out  = vld_reg;
    assign div_out  = div_reg;
    assign rem_out  = rem_reg;
    assign acc_out  = acc_reg;
    assign side_out = side_reg;

endmodule

>>> hw/rtl/rgbcct_div_chain.sv
// ============================================================================
// rgbcct_div_chain: row of division cells
// One cell per quotient bit. A new division enters every cycle; the quotient
// leaves in the accumulator of the last cell.
// ============================================================================
module rgbcct_div_chain #(
    parameter int DW = 32,
    parameter int AW = 32,
    parameter int LN = 1,
    parameter int SW = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  vld_in,
    input  logic [DW-1:0]         div_in,
    input  logic [LN-1:0][DW-1:0] rem_in,
    input  logic [LN-1:0][AW-1:0] acc_in,
    input  logic [SW-1:0]         side_in,
    output logic                  vld_out,
    output logic [LN-1:0][AW-1:0] quo_out,
    output logic [SW-1:0]         side_out
);

    logic                  vld  [AW+1];
    logic [DW-1:0]         dv   [AW+1];
    logic [LN-1:0][DW-1:0] rem  [AW+1];
    logic [LN-1:0][AW-1:0] acc  [AW+1];
    logic [SW-1:0]         side [AW+1];

    assign vld[0]  = vld_in;
    assign dv[0]   = div_in;
    assign rem[0]  = rem_in;
    assign acc[0]  = acc_in;
    assign side[0] = side_in;

    for (genvar k = 0; k < AW; k++)
    begin : g_cell
        rgbcct_div_cell #(
            .DW(DW),
            .AW(AW),
            .LN(LN),
            .SW(SW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .vld_in   (vld[k]),
            .div_in   (dv[k]),
            .rem_in   (rem[k]),
            .acc_in   (acc[k]),
            .side_in  (side[k]),
            .vld_out  (vld[k+1]),
            .div_out  (dv[k+1]),
            .rem_out  (rem[k+1]),
            .acc_out  (acc[k+1]),
            .side_out (side[k+1])
        );
    end

    assign vld_out  = vld[AW];
    assign quo_out  = acc[AW];
    assign side_out = side[AW];

endmodule

>>> hw/rtl/rgb_to_color_temperature.sv
// ============================================================================
// rgb_to_color_temperature: McCamy correlated color temperature from RGB
// Matrix to XYZ, chromaticity by two pipelined dividers, McCamy cubic.
// ============================================================================
// The block takes one sample per cycle and never raises busy. Each
// transaction yields exactly one result, strobed by done for a single cycle;
// the receiver cannot hold it off, so it must capture the result in that cycle.
// Most of the pipeline lies in the two chains of division cells, one cell per
// quotient bit: 31 + FRAC_BITS cells for x and y, and FRAC_BITS + 5 for n.
module rgb_to_color_temperature #(
    parameter int FRAC_BITS = rgbcct_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [rgbcct_pkg::CH_W-1:0]            red_count,
    input  logic [rgbcct_pkg::CH_W-1:0]            green_count,
    input  logic [rgbcct_pkg::CH_W-1:0]            blue_count,
    output logic                                   done,
    output logic signed [rgbcct_pkg::CCT_W-1:0]    cct_kelvin,
    output logic [rgbcct_pkg::LUX_W-1:0]           lux_value,
    output logic                                   sum_zero,
    output logic                                   saturated
);

    localparam int T_W    = rgbcct_pkg::T_W;
    localparam int S_W    = rgbcct_pkg::S_W;
    localparam int SMAG_W = rgbcct_pkg::SMAG_W;
    localparam int LUX_W  = rgbcct_pkg::LUX_W;
    localparam int NI_W   = rgbcct_pkg::N_INT_W;

    localparam int QX_W  = rgbcct_pkg::TMAG_W + FRAC_BITS;
    localparam int MAG_W = QX_W + 1;
    localparam int NUM_W = MAG_W + 1;
    localparam int NQ_W  = FRAC_BITS + NI_W;
    localparam int N_W   = NQ_W + 1;
    localparam int NP_W  = 2 * N_W;
    localparam int N2_W  = FRAC_BITS + 11;
    localparam int N3P_W = N2_W + N_W;
    localparam int N3_W  = N3P_W - FRAC_BITS;
    localparam int V_W   = FRAC_BITS + 27;
    localparam int C_W   = V_W - FRAC_BITS;
    localparam int SW1   = LUX_W + 3;
    localparam int SW2   = LUX_W + 3;
    localparam int LAT   = 12 + QX_W + NQ_W;

    localparam longint ONE_F = longint'(1) << FRAC_BITS;
    localparam longint X0_F  = (rgbcct_pkg::X0_NUM * ONE_F + rgbcct_pkg::SCALE_DEN / 2)
                               / rgbcct_pkg::SCALE_DEN;
    localparam longint Y0_F  = (rgbcct_pkg::Y0_NUM * ONE_F + rgbcct_pkg::SCALE_DEN / 2)
                               / rgbcct_pkg::SCALE_DEN;
    localparam logic signed [NUM_W-1:0] X0_C = NUM_W'(X0_F);
    localparam logic signed [NUM_W-1:0] Y0_C = NUM_W'(Y0_F);
    localparam logic signed [NUM_W-1:0] ZC_C = NUM_W'(rgbcct_pkg::ZERO_CHROMA * ONE_F);
    localparam logic signed [N_W-1:0]   NMAX_C = N_W'((longint'(1) << NQ_W) - 1);
    localparam logic signed [V_W-1:0]   HALF_C = V_W'(ONE_F >> 1);

    // ---------------------------------------------------------------- matrix
    logic [rgbcct_pkg::CH_W-1:0] ch [3];
    logic              vld1_reg, vld2_reg, vld3_reg, vld4_reg;
    logic signed [T_W-1:0] prod_next [3][3];
    logic signed [T_W-1:0] prod_reg  [3][3];
    logic signed [T_W-1:0] t_reg [3];
    logic signed [T_W-1:0] t0_reg, t1_reg;
    logic signed [S_W-1:0] s_reg;
    logic [LUX_W-1:0]      lux_next, lux3_reg;
    logic [T_W-rgbcct_pkg::LUX_SHIFT-1:0] lux_full;

    assign ch[0] = red_count;
    assign ch[1] = green_count;
    assign ch[2] = blue_count;
    assign busy  = 1'b0;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_next[i][j] = T_W'(signed'({1'b0, ch[j]})) * T_W'(rgbcct_pkg::MAT[i][j]);
            end
        end
    end

    assign lux_full = t_reg[1][T_W-1:rgbcct_pkg::LUX_SHIFT];

    always_comb
    begin
        if (t_reg[1][T_W-1])
        begin
            lux_next = '0;
        end
        else if (|lux_full[T_W-rgbcct_pkg::LUX_SHIFT-1:LUX_W])
        begin
            lux_next = '1;
        end
        else
        begin
            lux_next = lux_full[LUX_W-1:0];
        end
    end

    // ------------------------------------------------- sign and magnitude
    logic [SMAG_W-1:0]          d1_next;
    logic [1:0][SMAG_W-1:0]     rem1_init;
    logic [1:0][QX_W-1:0]       acc1_next;
    logic [SW1-1:0]             side1_next;
    logic [SMAG_W-1:0]          d1_reg;
    logic [1:0][QX_W-1:0]       acc1_reg;
    logic [SW1-1:0]             side1_reg;
    logic signed [T_W-1:0]      t0_abs, t1_abs;
    logic signed [S_W-1:0]      s_abs;

    always_comb
    begin
        t0_abs = t0_reg[T_W-1] ? -t0_reg : t0_reg;
        t1_abs = t1_reg[T_W-1] ? -t1_reg : t1_reg;
        s_abs  = s_reg[S_W-1] ? -s_reg : s_reg;
        d1_next = s_abs[SMAG_W-1:0];
        acc1_next[0] = {t0_abs[rgbcct_pkg::TMAG_W-1:0], FRAC_BITS'(0)};
        acc1_next[1] = {t1_abs[rgbcct_pkg::TMAG_W-1:0], FRAC_BITS'(0)};
        side1_next = {t0_reg[T_W-1] ^ s_reg[S_W-1], t1_reg[T_W-1] ^ s_reg[S_W-1],
                      s_reg == '0, lux3_reg};
    end

    assign rem1_init = '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= start && !busy;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        for (int i = 0; i < 3; i++)
        begin
            t_reg[i] <= prod_reg[i][0] + prod_reg[i][1] + prod_reg[i][2];
        end
        t0_reg    <= t_reg[0];
        t1_reg    <= t_reg[1];
        s_reg     <= S_W'(t_reg[0]) + S_W'(t_reg[1]) + S_W'(t_reg[2]);
        lux3_reg  <= lux_next;
        d1_reg    <= d1_next;
        acc1_reg  <= acc1_next;
        side1_reg <= side1_next;
    end

    // ------------------------------------------------ x and y dividers
    logic                 vld5;
    logic [1:0][QX_W-1:0] quo1;
    logic [SW1-1:0]       side1_out;

    rgbcct_div_chain #(
        .DW(SMAG_W),
        .AW(QX_W),
        .LN(2),
        .SW(SW1)
    ) u_xy_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld_in   (vld4_reg),
        .div_in   (d1_reg),
        .rem_in   (rem1_init),
        .acc_in   (acc1_reg),
        .side_in  (side1_reg),
        .vld_out  (vld5),
        .quo_out  (quo1),
        .side_out (side1_out)
    );

    // ------------------------------------------------ n = num / den
    logic                    vldp1_reg, vldp2_reg, vldp3_reg;
    logic signed [NUM_W-1:0] x_next, y_next, x_reg, y_reg;
    logic signed [NUM_W-1:0] num_reg, den_reg, num_abs, den_abs;
    logic [SW1-1:0]          sidep1_reg, sidep2_reg;
    logic [MAG_W-1:0]        d2_reg;
    logic [0:0][MAG_W-1:0]   rem2_reg;
    logic [0:0][NQ_W-1:0]    acc2_reg;
    logic [SW2-1:0]          side2_next, side2_reg;
    logic                    nsat;

    always_comb
    begin
        if (side1_out[LUX_W])
        begin
            x_next = ZC_C;
            y_next = ZC_C;
        end
        else
        begin
            x_next = side1_out[LUX_W+2] ? -NUM_W'(quo1[0]) : NUM_W'(quo1[0]);
            y_next = side1_out[LUX_W+1] ? -NUM_W'(quo1[1]) : NUM_W'(quo1[1]);
        end
    end

    always_comb
    begin
        num_abs = num_reg[NUM_W-1] ? -num_reg : num_reg;
        den_abs = den_reg[NUM_W-1] ? -den_reg : den_reg;
        // Saturate when the integer part of the quotient reaches 32.
        nsat = (MAG_W + NI_W)'(num_abs[MAG_W-1:0])
               >= {den_abs[MAG_W-1:0], NI_W'(0)};
        side2_next = {nsat,
                      (den_abs == '0) ? num_reg[NUM_W-1]
                                      : (num_reg[NUM_W-1] ^ den_reg[NUM_W-1]),
                      sidep2_reg[LUX_W], sidep2_reg[LUX_W-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vldp1_reg <= 1'b0;
            vldp2_reg <= 1'b0;
            vldp3_reg <= 1'b0;
        end
        else
        begin
            vldp1_reg <= vld5;
            vldp2_reg <= vldp1_reg;
            vldp3_reg <= vldp2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        sidep1_reg  <= side1_out;
        num_reg     <= x_reg - X0_C;
        den_reg     <= Y0_C - y_reg;
        sidep2_reg  <= sidep1_reg;
        d2_reg      <= den_abs[MAG_W-1:0];
        rem2_reg[0] <= MAG_W'(num_abs[MAG_W-1:NI_W]);
        acc2_reg[0] <= {num_abs[NI_W-1:0], FRAC_BITS'(0)};
        side2_reg   <= side2_next;
    end

    logic                 vld6;
    logic [0:0][NQ_W-1:0] quo2;
    logic [SW2-1:0]       side2_out;

    rgbcct_div_chain #(
        .DW(MAG_W),
        .AW(NQ_W),
        .LN(1),
        .SW(SW2)
    ) u_n_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld_in   (vldp3_reg),
        .div_in   (d2_reg),
        .rem_in   (rem2_reg),
        .acc_in   (acc2_reg),
        .side_in  (side2_reg),
        .vld_out  (vld6),
        .quo_out  (quo2),
        .side_out (side2_out)
    );

    // ------------------------------------------------ cubic
    logic                    vldq_reg, vldm1_reg, vldm2_reg, vldm3_reg, done_reg;
    logic signed [N_W-1:0]   n_next, n_reg, n1_reg, n2p_reg;
    logic signed [N_W-1:0]   nq_mag;
    logic signed [NP_W-1:0]  nsq_reg;
    logic signed [N2_W-1:0]  n2_next, n2_reg;
    logic signed [N3P_W-1:0] n3p_reg;
    logic signed [N3_W-1:0]  n3;
    logic signed [V_W-1:0]   v_next, v_reg, v_round;
    logic signed [C_W-1:0]   c_full;
    logic [SW2-1:0]          sideq_reg, sidem1_reg, sidem2_reg, sidem3_reg;
    logic                    c_hi, c_lo;

    always_comb
    begin
        nq_mag = side2_out[SW2-1] ? NMAX_C : N_W'(quo2[0]);
        n_next = side2_out[SW2-2] ? -nq_mag : nq_mag;
    end

    assign n2_next = N2_W'(nsq_reg >>> FRAC_BITS);
    assign n3      = N3_W'(n3p_reg >>> FRAC_BITS);

    always_comb
    begin
        v_next = V_W'(n3) * V_W'(rgbcct_pkg::POLY_C3)
               + V_W'(n2_reg) * V_W'(rgbcct_pkg::POLY_C2)
               + V_W'(n2p_reg) * V_W'(rgbcct_pkg::POLY_C1)
               + (V_W'(rgbcct_pkg::POLY_C0) <<< FRAC_BITS);
    end

    always_comb
    begin
        v_round = v_reg + HALF_C;
        c_full  = C_W'(v_round >>> FRAC_BITS);
        c_hi    = c_full > C_W'(rgbcct_pkg::CCT_MAX);
        c_lo    = c_full < C_W'(rgbcct_pkg::CCT_MIN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vldq_reg  <= 1'b0;
            vldm1_reg <= 1'b0;
            vldm2_reg <= 1'b0;
            vldm3_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            vldq_reg  <= vld6;
            vldm1_reg <= vldq_reg;
            vldm2_reg <= vldm1_reg;
            vldm3_reg <= vldm2_reg;
            done_reg  <= vldm3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        sideq_reg  <= side2_out;
        nsq_reg    <= NP_W'(n_reg) * NP_W'(n_reg);
        n1_reg     <= n_reg;
        sidem1_reg <= sideq_reg;
        n2_reg     <= n2_next;
        n3p_reg    <= N3P_W'(n2_next) * N3P_W'(n1_reg);
        n2p_reg    <= n1_reg;
        sidem2_reg <= sidem1_reg;
        v_reg      <= v_next;
        sidem3_reg <= sidem2_reg;
        if (c_hi)
        begin
            cct_kelvin <= rgbcct_pkg::CCT_W'(rgbcct_pkg::CCT_MAX);
        end
        else if (c_lo)
        begin
            cct_kelvin <= rgbcct_pkg::CCT_W'(rgbcct_pkg::CCT_MIN);
        end
        else
        begin
            cct_kelvin <= c_full[rgbcct_pkg::CCT_W-1:0];
        end
        lux_value <= sidem3_reg[LUX_W-1:0];
        sum_zero  <= sidem3_reg[LUX_W];
        saturated <= sidem3_reg[SW2-1] || c_hi || c_lo;
    end

    assign done = done_reg;

    // ------------------------------------------------ assertions
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted transaction produced no result");

    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without an accepted transaction");

    a_zero_sum_nosat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(sum_zero && saturated))
        else $error("default chromaticity must not saturate");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top: testbench for rgb_to_color_temperature
// Sends RGB samples through the command handshake and predicts the color
// temperature, lux and flags of each one. Every done strobe is checked field
// by field against the oldest pending prediction. The run covers directed
// corner samples and random samples under several sender idle rates.
// ============================================================================
module tb_top;

    localparam int  CH_W        = rgbcct_pkg::CH_W;
    localparam int  CCT_W       = rgbcct_pkg::CCT_W;
    localparam int  LUX_W       = rgbcct_pkg::LUX_W;
    localparam int  LUX_SHIFT   = rgbcct_pkg::LUX_SHIFT;
    localparam int  ZERO_CHROMA = rgbcct_pkg::ZERO_CHROMA;
    localparam int  X0_NUM      = rgbcct_pkg::X0_NUM;
    localparam int  Y0_NUM      = rgbcct_pkg::Y0_NUM;
    localparam int  SCALE_DEN   = rgbcct_pkg::SCALE_DEN;
    localparam int  POLY_C3     = rgbcct_pkg::POLY_C3;
    localparam int  POLY_C2     = rgbcct_pkg::POLY_C2;
    localparam int  POLY_C1     = rgbcct_pkg::POLY_C1;
    localparam int  POLY_C0     = rgbcct_pkg::POLY_C0;
    localparam int  CCT_MAX     = rgbcct_pkg::CCT_MAX;
    localparam int  CCT_MIN     = rgbcct_pkg::CCT_MIN;

    localparam int  FB        = rgbcct_pkg::FRAC_BITS_DEF;
    localparam int  TIMEOUT   = 200000;
    localparam int  DRAIN_CYC = 2 * FB + 48 + 20;
    localparam longint ONE_F  = longint'(1) << FB;
    localparam longint N_MAX  = (longint'(32) << FB) - 1;

    typedef struct packed {
        logic signed [CCT_W-1:0] cct;
        logic [LUX_W-1:0]        lux;
        logic                    zero_sum;
        logic                    sat;
    } cct_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [CH_W-1:0]         red_count = '0;
    logic [CH_W-1:0]         green_count = '0;
    logic [CH_W-1:0]         blue_count = '0;
    logic                    done;
    logic signed [CCT_W-1:0] cct_kelvin;
    logic [LUX_W-1:0]        lux_value;
    logic                    sum_zero;
    logic                    saturated;

    cct_result_t pending_results[$];
    int          mismatches = 0;
    int          cycles = 0;

    rgb_to_color_temperature DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .red_count(red_count), .green_count(green_count), .blue_count(blue_count),
        .done(done), .cct_kelvin(cct_kelvin), .lux_value(lux_value),
        .sum_zero(sum_zero), .saturated(saturated)
    );

    always #2 clk = ~clk;

    // McCamy temperature in fixed point: matrix, chromaticity, n, cubic.
    function automatic cct_result_t mccamy_from_rgb(input logic [CH_W-1:0] r, g, b);
        longint      ch[3];
        longint      t[3];
        longint      s, x, y, num, den, a, d, n, n2, n3, v, c, x0, y0;
        bit          neg;
        cct_result_t res;
        ch[0] = r;
        ch[1] = g;
        ch[2] = b;
        for (int i = 0; i < 3; i++)
        begin
            t[i] = longint'(rgbcct_pkg::MAT[i][0]) * ch[0]
                 + longint'(rgbcct_pkg::MAT[i][1]) * ch[1]
                 + longint'(rgbcct_pkg::MAT[i][2]) * ch[2];
        end
        s = t[0] + t[1] + t[2];
        res.zero_sum = (s == 0);
        res.sat = 1'b0;
        if (s != 0)
        begin
            x = (t[0] * ONE_F) / s;
            y = (t[1] * ONE_F) / s;
        end
        else
        begin
            x = ZERO_CHROMA * ONE_F;
            y = ZERO_CHROMA * ONE_F;
        end
        x0 = (X0_NUM * ONE_F + SCALE_DEN / 2) / SCALE_DEN;
        y0 = (Y0_NUM * ONE_F + SCALE_DEN / 2) / SCALE_DEN;
        num = x - x0;
        den = y0 - y;
        neg = (num < 0) != (den < 0);
        a = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        if (d == 0)
        begin
            res.sat = 1'b1;
            n = (num < 0) ? -N_MAX : N_MAX;
        end
        else if (a / d >= 32)
        begin
            res.sat = 1'b1;
            n = neg ? -N_MAX : N_MAX;
        end
        else
        begin
            n = (a << FB) / d;
            if (neg)
                n = -n;
        end
        n2 = (n * n) >>> FB;
        n3 = (n2 * n) >>> FB;
        v = POLY_C3 * n3 + POLY_C2 * n2 + POLY_C1 * n + POLY_C0 * ONE_F;
        c = (v + ONE_F / 2) >>> FB;
        if (c > CCT_MAX)
        begin
            c = CCT_MAX;
            res.sat = 1'b1;
        end
        else if (c < CCT_MIN)
        begin
            c = CCT_MIN;
            res.sat = 1'b1;
        end
        res.cct = c[CCT_W-1:0];
        if (t[1] <= 0)
            res.lux = '0;
        else if ((t[1] >>> LUX_SHIFT) > 65535)
            res.lux = 16'hFFFF;
        else
            res.lux = LUX_W'(t[1] >>> LUX_SHIFT);
        return res;
    endfunction

    // Predict on every accepted transaction and check every done strobe.
    always @(posedge clk)
    begin
        cct_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result cct=%0d lux=%0d", cct_kelvin,
                                 lux_value);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (want.cct !== cct_kelvin || want.lux !== lux_value
                        || want.zero_sum !== sum_zero || want.sat !== saturated)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("ERROR: expected cct=%0d lux=%0d zero=%b sat=%b",
                                     want.cct, want.lux, want.zero_sum, want.sat);
                            $display("       got      cct=%0d lux=%0d zero=%b sat=%b",
                                     cct_kelvin, lux_value, sum_zero, saturated);
                        end
                    end
                end
            end
            if (start && !busy)
                pending_results.push_back(mccamy_from_rgb(red_count, green_count,
                                                          blue_count));
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > TIMEOUT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Sends one sample after a random gap; returns right after the accepting edge.
    task automatic send_sample(input logic [CH_W-1:0] r, g, b, input int idle_pct);
        int   gap;
        logic was_busy;
        gap = 0;
        while (idle_pct > 0 && $urandom_range(99) < idle_pct && gap < 40)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        red_count <= r;
        green_count <= g;
        blue_count <= b;
        do
        begin
            @(negedge clk);
            was_busy = busy;
            @(posedge clk);
        end while (was_busy);
    endtask

    task automatic send_random(input int idle_pct);
        logic [CH_W-1:0] r, g, b;
        r = CH_W'($urandom);
        g = CH_W'($urandom);
        b = CH_W'($urandom);
        case ($urandom_range(5))
            0:
            begin
                r = CH_W'($urandom_range(255));
                g = CH_W'($urandom_range(255));
                b = CH_W'($urandom_range(255));
            end
            1:
            begin
                g = CH_W'(r + $urandom_range(64));
                b = CH_W'(r - $urandom_range(64));
            end
            2: r = 0;
            3: b = 0;
            default: ;
        endcase
        send_sample(r, g, b, idle_pct);
    endtask

    task automatic test_corners();
        send_sample(16'h0000, 16'h0000, 16'h0000, 0);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
        send_sample(16'hFFFF, 16'h0000, 16'h0000, 0);
        send_sample(16'h0000, 16'hFFFF, 16'h0000, 0);
        send_sample(16'h0000, 16'h0000, 16'hFFFF, 0);
        send_sample(16'hFFFF, 16'hFFFF, 16'h0000, 0);
        send_sample(16'h0000, 16'hFFFF, 16'hFFFF, 0);
        send_sample(16'hFFFF, 16'h0000, 16'hFFFF, 0);
        send_sample(16'h0001, 16'h0000, 16'h0000, 0);
        send_sample(16'h0000, 16'h0001, 16'h0000, 0);
        send_sample(16'h0000, 16'h0000, 16'h0001, 0);
        send_sample(16'h0001, 16'h0001, 16'h0001, 0);
        send_sample(16'd1000, 16'd1000, 16'd1000, 0);
        send_sample(16'd3000, 16'd2000, 16'd1000, 0);
        send_sample(16'd1000, 16'd2000, 16'd3000, 0);
        send_sample(16'h5555, 16'hAAAA, 16'h5555, 0);
        send_sample(16'hAAAA, 16'h5555, 16'hAAAA, 0);
        send_sample(16'd100, 16'd300, 16'd100, 0);
        send_sample(16'd900, 16'd100, 16'd50, 0);
    endtask

    task automatic test_random_phase(input int count, input int idle_pct);
        repeat (count) send_random(idle_pct);
    endtask

    // The sender holds off until every pending transaction has been checked.
    task automatic test_drain_pause();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        test_random_phase(20, 0);
    endtask

    initial
    begin
        int tail;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corners();
        test_random_phase(220, 0);
        test_random_phase(200, 83);
        test_drain_pause();
        test_random_phase(200, 30);
        test_random_phase(200, 0);
        start <= 1'b0;
        tail = 0;
        while (pending_results.size() != 0 && tail < 10 * DRAIN_CYC)
        begin
            @(posedge clk);
            tail++;
        end
        repeat (DRAIN_CYC) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
